### src/edd_pkg.sv
// Shared types and constants of the edit distance engine.
`default_nettype none

package edd_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned DIST_W      = 6;
   localparam int unsigned LIMIT_W     = 6;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd3;
   localparam logic [DIST_W-1:0]  DIST_MAX    = 6'd63;

   typedef enum logic [1:0] {
      CMD_APPEND_FIRST  = 2'd0,
      CMD_APPEND_SECOND = 2'd1,
      CMD_COMPUTE       = 2'd2,
      CMD_CLEAR         = 2'd3
   } command_type;

   typedef struct packed {
      command_type       command;
      logic [CHAR_W-1:0] char_value;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              is_near;
      logic              overflowed;
   } rsp_type;

endpackage

`default_nettype wire

### src/edit_distance_engine.sv
// Levenshtein edit distance engine: word stores, row memory and cell sequencer.
//
//   channel   ports                         direction  handshake
//   request   start, busy, req_data         in         taken when start high, busy low
//   response  rsp_strobe, rsp_data          out        one cycle, no back-pressure
//   config    csr_we, csr_wdata             in         written when csr_we high
//
// Appends and clears never raise busy.
// A compute with both words non-empty walks the m x n cell grid one cell a cycle
// through the 1R1W row memory (read at issue, written back by the execute stage):
// busy stays high through the walk and a drain state, and falls as the response appears.
// A compute with an empty word answers in the next cycle without raising busy.
// Reset empties both words, clears the drop flag and sets the near limit to 3.
// Word stores and row memory need no clearing pass; row one is built from j.
`default_nettype none

module edit_distance_engine #(
   parameter int unsigned MAX_LEN = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire edd_pkg::req_type             req_data,
   output      logic                         rsp_strobe,
   output      edd_pkg::rsp_type             rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [edd_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned EW = (LW > edd_pkg::DIST_W) ? LW : edd_pkg::DIST_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // Memories
   logic [edd_pkg::CHAR_W-1:0] first_mem  [MAX_LEN];
   logic [edd_pkg::CHAR_W-1:0] second_mem [MAX_LEN];
   logic [LW-1:0]              cost_mem   [MAX_LEN];

   // Control and datapath registers
   state_type                   state_ff, state_in;
   logic [LW-1:0]               first_len_ff, first_len_in;
   logic [LW-1:0]               second_len_ff, second_len_in;
   logic                        drop_ff, drop_in;
   logic [edd_pkg::LIMIT_W-1:0] limit_ff;
   logic [LW-1:0]               i_ff, i_in;
   logic [LW-1:0]               j_ff, j_in;
   logic                        exe_valid_ff;
   logic                        exe_last_ff;
   logic [LW-1:0]               exe_i_ff;
   logic [LW-1:0]               exe_j_ff;
   logic [LW-1:0]               left_ff;
   logic [LW-1:0]               diag_ff;
   logic                        fwd_ff;
   logic [LW-1:0]               fwd_data_ff;
   logic [edd_pkg::CHAR_W-1:0]  first_rd_ff;
   logic [edd_pkg::CHAR_W-1:0]  second_rd_ff;
   logic [LW-1:0]               cost_rd_ff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   edd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // Combinational signals
   logic          accept;
   logic          issue;
   logic          issue_row_end;
   logic          issue_last;
   logic [AW-1:0] issue_addr;
   logic [AW-1:0] exe_addr;
   logic [LW-1:0] im1;
   logic [LW-1:0] jm1;
   logic [LW-1:0] exm1;
   logic [LW-1:0] up_w;
   logic [LW-1:0] left_w;
   logic [LW-1:0] diag_w;
   logic [LW:0]   c_up;
   logic [LW:0]   c_left;
   logic [LW:0]   c_diag;
   logic [LW:0]   c_min;
   logic [LW-1:0] cell_w;
   logic [LW-1:0] dist_w;
   logic          first_full;
   logic          second_full;

   assign accept        = start && (state_ff == ST_IDLE);
   assign busy          = (state_ff != ST_IDLE);
   assign issue         = (state_ff == ST_ISSUE);
   assign issue_row_end = (j_ff == second_len_ff);
   assign issue_last    = issue_row_end && (i_ff == first_len_ff);
   assign im1           = i_ff - LW'(1);
   assign jm1           = j_ff - LW'(1);
   assign exm1          = exe_j_ff - LW'(1);
   assign issue_addr    = jm1[AW-1:0];
   assign exe_addr      = exm1[AW-1:0];
   assign first_full    = (first_len_ff == LW'(MAX_LEN));
   assign second_full   = (second_len_ff == LW'(MAX_LEN));

   // Evaluate one cell: row one takes j as the row above, first column edges use i
   always_comb begin
      if (exe_i_ff == LW'(1)) begin
         up_w = exe_j_ff;
      end else if (fwd_ff) begin
         up_w = fwd_data_ff;
      end else begin
         up_w = cost_rd_ff;
      end
      left_w = (exe_j_ff == LW'(1)) ? exe_i_ff : left_ff;
      diag_w = (exe_j_ff == LW'(1)) ? (exe_i_ff - LW'(1)) : diag_ff;
      c_up   = {1'b0, up_w} + (LW+1)'(1);
      c_left = {1'b0, left_w} + (LW+1)'(1);
      c_diag = {1'b0, diag_w} + (LW+1)'(first_rd_ff != second_rd_ff);
      c_min  = (c_up < c_left) ? c_up : c_left;
      c_min  = (c_diag < c_min) ? c_diag : c_min;
      cell_w = c_min[LW-1:0];
   end

   // Sequence the cell walk and the load commands
   always_comb begin
      state_in      = state_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      drop_in       = drop_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  edd_pkg::CMD_APPEND_FIRST: begin
                     if (first_full) begin
                        drop_in = 1'b1;
                     end else begin
                        first_len_in = first_len_ff + LW'(1);
                     end
                  end
                  edd_pkg::CMD_APPEND_SECOND: begin
                     if (second_full) begin
                        drop_in = 1'b1;
                     end else begin
                        second_len_in = second_len_ff + LW'(1);
                     end
                  end
                  edd_pkg::CMD_COMPUTE: begin
                     if ((first_len_ff != '0) && (second_len_ff != '0)) begin
                        state_in = ST_ISSUE;
                        i_in     = LW'(1);
                        j_in     = LW'(1);
                     end
                  end
                  edd_pkg::CMD_CLEAR: begin
                     first_len_in  = '0;
                     second_len_in = '0;
                     drop_in       = 1'b0;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end else if (issue_row_end) begin
               i_in = i_ff + LW'(1);
               j_in = LW'(1);
            end else begin
               j_in = j_ff + LW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Form the response word: end of the walk, or an empty word at once
   always_comb begin
      rsp_strobe_in = 1'b0;
      dist_w        = cell_w;
      priority if (exe_valid_ff && exe_last_ff) begin
         rsp_strobe_in = 1'b1;
      end else if (accept && (req_data.command == edd_pkg::CMD_COMPUTE)
                   && ((first_len_ff == '0) || (second_len_ff == '0))) begin
         rsp_strobe_in = 1'b1;
         dist_w        = (first_len_ff == '0) ? second_len_ff : first_len_ff;
      end else begin
         rsp_strobe_in = 1'b0;
      end
      rsp_data_in.distance   = (EW'(dist_w) > EW'(edd_pkg::DIST_MAX)) ?
                               edd_pkg::DIST_MAX : edd_pkg::DIST_W'(dist_w);
      rsp_data_in.is_near    = (EW'(dist_w) < EW'(limit_ff));
      rsp_data_in.overflowed = drop_ff;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         drop_ff       <= 1'b0;
         limit_ff      <= edd_pkg::LIMIT_RESET;
         exe_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         drop_ff       <= drop_in;
         exe_valid_ff  <= issue;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Advance the issue counters and the execute stage
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      exe_i_ff     <= i_ff;
      exe_j_ff     <= j_ff;
      exe_last_ff  <= issue_last;
      left_ff      <= cell_w;
      diag_ff      <= up_w;
      fwd_ff       <= issue && exe_valid_ff && (issue_addr == exe_addr);
      fwd_data_ff  <= cell_w;
      rsp_data_ff  <= rsp_data_in;
   end

   // First word store: append on load, read the row character at each row start
   always_ff @(posedge clock) begin
      if (accept && (req_data.command == edd_pkg::CMD_APPEND_FIRST) && !first_full) begin
         first_mem[first_len_ff[AW-1:0]] <= req_data.char_value;
      end
      if (issue && (j_ff == LW'(1))) begin
         first_rd_ff <= first_mem[im1[AW-1:0]];
      end
   end

   // Second word store: append on load, read one character per cell
   always_ff @(posedge clock) begin
      if (accept && (req_data.command == edd_pkg::CMD_APPEND_SECOND) && !second_full) begin
         second_mem[second_len_ff[AW-1:0]] <= req_data.char_value;
      end
      if (issue) begin
         second_rd_ff <= second_mem[issue_addr];
      end
   end

   // Row memory: read the cell above, write back the finished cell
   always_ff @(posedge clock) begin
      if (exe_valid_ff) begin
         cost_mem[exe_addr] <= cell_w;
      end
      if (issue) begin
         cost_rd_ff <= cost_mem[issue_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the edit distance engine.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned WORD_MAX   = 32;
   localparam int unsigned PHASE_SIZE = 200;

   // One row of the directed stimulus table
   typedef struct {
      edd_pkg::req_type word;
      int unsigned      repeats;
      bit               typed;
      edd_pkg::rsp_type answer;
   } plan_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   edd_pkg::req_type            req_data = '0;
   logic                        rsp_strobe;
   edd_pkg::rsp_type            rsp_data;
   logic                        csr_we = 1'b0;
   logic [edd_pkg::LIMIT_W-1:0] csr_wdata = '0;

   // Shadow copy of the two words, the drop flag and the near limit
   logic [edd_pkg::CHAR_W-1:0]  word_a [WORD_MAX];
   logic [edd_pkg::CHAR_W-1:0]  word_b [WORD_MAX];
   int unsigned                 len_a = 0;
   int unsigned                 len_b = 0;
   logic                        dropped = 1'b0;
   logic [edd_pkg::LIMIT_W-1:0] limit_now = edd_pkg::LIMIT_RESET;

   edd_pkg::rsp_type            pending_distances [$];
   plan_row_type                directed_plan [$];
   int unsigned                 words_sent = 0;
   int unsigned                 mismatches = 0;
   bit                          idling_on = 1'b1;

   edit_distance_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Predict the answer of a compute from the shadow words
   function automatic edd_pkg::rsp_type levenshtein_result();
      int               cost [WORD_MAX+1];
      int               diag;
      int               up;
      int               best;
      int               edits;
      edd_pkg::rsp_type r;
      if (len_a == 0) begin
         edits = len_b;
      end else if (len_b == 0) begin
         edits = len_a;
      end else begin
         for (int j = 0; j <= len_b; j++) cost[j] = j;
         for (int i = 1; i <= len_a; i++) begin
            diag    = cost[0];
            cost[0] = i;
            for (int j = 1; j <= len_b; j++) begin
               up   = cost[j];
               best = up + 1;
               if (cost[j-1] + 1 < best) best = cost[j-1] + 1;
               if (diag + ((word_b[j-1] == word_a[i-1]) ? 0 : 1) < best)
                  best = diag + ((word_b[j-1] == word_a[i-1]) ? 0 : 1);
               cost[j] = best;
               diag    = up;
            end
         end
         edits = cost[len_b];
      end
      r.distance   = (edits > int'(edd_pkg::DIST_MAX)) ? edd_pkg::DIST_MAX :
                     edd_pkg::DIST_W'(edits);
      r.is_near    = (edits < int'(limit_now));
      r.overflowed = dropped;
      return r;
   endfunction

   // Hold a word on the request port until taken, then update the shadow state
   task automatic send_word(input edd_pkg::req_type w, input bit typed = 1'b0,
                            input edd_pkg::rsp_type answer = '0);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      words_sent++;
      case (w.command)
         edd_pkg::CMD_APPEND_FIRST: begin
            if (len_a < WORD_MAX) begin
               word_a[len_a] = w.char_value;
               len_a++;
            end else begin
               dropped = 1'b1;
            end
         end
         edd_pkg::CMD_APPEND_SECOND: begin
            if (len_b < WORD_MAX) begin
               word_b[len_b] = w.char_value;
               len_b++;
            end else begin
               dropped = 1'b1;
            end
         end
         edd_pkg::CMD_COMPUTE: begin
            pending_distances.push_back(typed ? answer : levenshtein_result());
         end
         default: begin
            len_a   = 0;
            len_b   = 0;
            dropped = 1'b0;
         end
      endcase
      @(negedge clock);
   endtask

   // Drop start now and then, at random
   task automatic maybe_idle();
      if (idling_on && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
   endtask

   // Hold off until every expected answer has come back
   task automatic settle();
      start <= 1'b0;
      while (pending_distances.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [edd_pkg::LIMIT_W-1:0] value);
      settle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      limit_now  = value;
      @(negedge clock);
   endtask

   function automatic logic [edd_pkg::CHAR_W-1:0] pick_char(input bit narrow);
      return narrow ? edd_pkg::CHAR_W'(8'h61 + $urandom_range(0, 2)) :
                      edd_pkg::CHAR_W'($urandom_range(255));
   endfunction

   // Maybe clear, load two words with random content, interleaved, then compute
   task automatic run_sequence();
      int unsigned      na;
      int unsigned      nb;
      bit               wide;
      bit               narrow;
      edd_pkg::req_type w;
      if ($urandom_range(3) != 0)
         send_word('{edd_pkg::CMD_CLEAR, edd_pkg::CHAR_W'($urandom_range(255))});
      wide   = ($urandom_range(15) == 0);
      narrow = 1'($urandom_range(1));
      na     = wide ? $urandom_range(20, 36) : $urandom_range(0, 6);
      nb     = wide ? $urandom_range(20, 36) : $urandom_range(0, 6);
      while (na > 0 || nb > 0) begin
         maybe_idle();
         if (nb == 0 || (na > 0 && $urandom_range(1) == 0)) begin
            w = '{edd_pkg::CMD_APPEND_FIRST, pick_char(narrow)};
            na--;
         end else begin
            w = '{edd_pkg::CMD_APPEND_SECOND, pick_char(narrow)};
            nb--;
         end
         send_word(w);
      end
      repeat ($urandom_range(1, 2)) begin
         maybe_idle();
         send_word('{edd_pkg::CMD_COMPUTE, edd_pkg::CHAR_W'($urandom_range(255))});
      end
   endtask

   task automatic plan(input edd_pkg::command_type c,
                       input logic [edd_pkg::CHAR_W-1:0] ch,
                       input int unsigned reps = 1, input bit typed = 1'b0,
                       input logic [edd_pkg::DIST_W-1:0] exp_dist = '0,
                       input logic near = 1'b0, input logic ovf = 1'b0);
      plan_row_type r;
      r.word    = '{c, ch};
      r.repeats = reps;
      r.typed   = typed;
      r.answer  = '{exp_dist, near, ovf};
      directed_plan.push_back(r);
   endtask

   // Check each answer word against the oldest expectation
   always @(posedge clock) begin
      edd_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_distances.size() == 0) begin
            $error("unexpected answer word: distance %0d", rsp_data.distance);
            mismatches++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_data.distance);
               mismatches++;
            end
            if (rsp_data.is_near !== want.is_near) begin
               $error("is_near: expected %0d, got %0d", want.is_near, rsp_data.is_near);
               mismatches++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0d, got %0d", want.overflowed,
                      rsp_data.overflowed);
               mismatches++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [edd_pkg::LIMIT_W-1:0] limits [7];
      edd_pkg::req_type            noise;

      // Directed words: empty words, zero byte, full words, clear
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd0,  1'b1, 1'b0);
      plan(edd_pkg::CMD_APPEND_FIRST,  8'h00);
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd1,  1'b1, 1'b0);
      plan(edd_pkg::CMD_APPEND_SECOND, 8'hFF);
      plan(edd_pkg::CMD_COMPUTE,       8'h00);
      plan(edd_pkg::CMD_APPEND_FIRST,  8'hFF);
      plan(edd_pkg::CMD_APPEND_SECOND, 8'h00);
      plan(edd_pkg::CMD_COMPUTE,       8'hFF);
      plan(edd_pkg::CMD_CLEAR,         8'h00);
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd0,  1'b1, 1'b0);
      plan(edd_pkg::CMD_APPEND_FIRST,  8'hAA, 33);
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd32, 1'b0, 1'b1);
      plan(edd_pkg::CMD_APPEND_SECOND, 8'hAA, 34);
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd0,  1'b1, 1'b1);
      plan(edd_pkg::CMD_CLEAR,         8'h00);
      plan(edd_pkg::CMD_COMPUTE,       8'h00, 1, 1'b1, 6'd0,  1'b1, 1'b0);
      plan(edd_pkg::CMD_APPEND_SECOND, 8'h55, 3);
      plan(edd_pkg::CMD_APPEND_FIRST,  8'h55);
      plan(edd_pkg::CMD_COMPUTE,       8'h00);
      plan(edd_pkg::CMD_APPEND_FIRST,  8'hAA, 2);
      plan(edd_pkg::CMD_COMPUTE,       8'h00);
      plan(edd_pkg::CMD_CLEAR,         8'hFF);
      plan(edd_pkg::CMD_COMPUTE,       8'hFF, 1, 1'b1, 6'd0,  1'b1, 1'b0);

      // Hold reset, then release it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[k]) begin
         repeat (directed_plan[k].repeats) begin
            maybe_idle();
            send_word(directed_plan[k].word, directed_plan[k].typed,
                      directed_plan[k].answer);
         end
      end

      // Random phases, each under its own near limit
      limits = '{6'd0, 6'd32, 6'd31, 6'd1, edd_pkg::LIMIT_W'($urandom_range(0, 32)),
                 edd_pkg::LIMIT_W'($urandom_range(0, 32)), edd_pkg::LIMIT_RESET};
      for (int p = 0; p < 7; p++) begin
         write_limit(limits[p]);
         idling_on = (p != 2);
         while (words_sent < directed_plan.size() + (p + 1) * PHASE_SIZE) begin
            maybe_idle();
            if ($urandom_range(99) < 85) begin
               run_sequence();
            end else begin
               noise.command    = edd_pkg::command_type'($urandom_range(3));
               noise.char_value = edd_pkg::CHAR_W'($urandom_range(255));
               send_word(noise);
            end
            if ($urandom_range(49) == 0) settle();
         end
      end

      // Drain the last answers
      start <= 1'b0;
      while (pending_distances.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
